/* sv/context_golomb_image_coder_core_defines.svh */
// Assertion helpers for the coder core.
`ifndef CONTEXT_GOLOMB_IMAGE_CODER_CORE_DEFINES_SVH
`define CONTEXT_GOLOMB_IMAGE_CODER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GCIC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define GCIC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/gcic_pkg.sv */
package gcic_pkg;

  localparam int MAX_WIDTH     = 4096;
  localparam int PIXEL_BITS    = 8;
  localparam int CONTEXT_COUNT = 405;
  localparam int COL_W         = $clog2(MAX_WIDTH);
  localparam int CTX_AW        = $clog2(CONTEXT_COUNT);
  localparam int SUM_W         = 17;
  localparam int CNT_W         = 9;
  localparam int CTX_DW        = SUM_W + CNT_W;

  localparam logic [SUM_W:0] SUM_MAX = 18'd131071;

  // floor(s/6) == (s * RECIP6) >> 18 for s below 1536
  localparam logic [15:0] RECIP6       = 16'd43691;
  localparam int          RECIP6_SHIFT = 18;

  // Context index weights
  localparam logic [CTX_AW-1:0] CTX_WA = 9'd45;
  localparam logic [CTX_AW-1:0] CTX_WB = 9'd5;
  localparam logic [CTX_AW-1:0] CTX_LAST = 9'(CONTEXT_COUNT - 1);

  // Register indexes
  localparam logic [2:0] REG_IMAGE_WIDTH = 3'd0;
  localparam logic [2:0] REG_WHITE_LEVEL = 3'd1;
  localparam logic [2:0] REG_MAX_COUNT   = 3'd2;
  localparam logic [2:0] REG_INIT_SUM    = 3'd3;
  localparam logic [2:0] REG_INIT_COUNT  = 3'd4;

  // Register reset values
  localparam logic [12:0] RST_IMAGE_WIDTH = 13'd640;
  localparam logic [7:0]  RST_WHITE_LEVEL = 8'd255;
  localparam logic [8:0]  RST_MAX_COUNT   = 9'd64;
  localparam logic [11:0] RST_INIT_SUM    = 12'd4;
  localparam logic [8:0]  RST_INIT_COUNT  = 9'd1;

  // Byte counts of a result
  localparam logic [1:0] BYTES_ONE = 2'd1;
  localparam logic [1:0] BYTES_TWO = 2'd2;

  // One code to emit: k remainder bits of m, then tail-1 zeros and a one
  typedef struct packed {
    logic [4:0] k;
    logic [8:0] m;
    logic [9:0] tail;
    logic       last;
  } gcic_cmd_t;

  function automatic logic [3:0] class9(input logic signed [9:0] g);
    logic [3:0] r;
    if (g < -10'sd21)      r = 4'd0;
    else if (g < -10'sd7)  r = 4'd1;
    else if (g < -10'sd3)  r = 4'd2;
    else if (g < 10'sd0)   r = 4'd3;
    else if (g == 10'sd0)  r = 4'd4;
    else if (g <= 10'sd3)  r = 4'd5;
    else if (g <= 10'sd7)  r = 4'd6;
    else if (g <= 10'sd21) r = 4'd7;
    else                   r = 4'd8;
    return r;
  endfunction

  function automatic logic [2:0] class5(input logic signed [9:0] g);
    logic [2:0] r;
    if (g < -10'sd3)      r = 3'd0;
    else if (g < 10'sd0)  r = 3'd1;
    else if (g == 10'sd0) r = 3'd2;
    else if (g <= 10'sd3) r = 3'd3;
    else                  r = 3'd4;
    return r;
  endfunction

endpackage

/* sv/gcic_ram.sv */
module gcic_ram #(
  parameter int DEPTH = 405,
  parameter int WIDTH = 26
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, read before write, registered read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* sv/gcic_packer.sv */
module gcic_packer
  import gcic_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  gcic_cmd_t        cmd,
  output logic             busy,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [15:0]      code_word,
  output logic [1:0]       byte_count,
  output logic             last_word
);

  typedef enum logic [1:0] {P_IDLE, P_REM, P_TAIL, P_FLUSH} phase_t;

  phase_t      phase;
  logic [16:0] rem_val;
  logic [4:0]  rem_left;
  logic [9:0]  tail_left;
  logic        is_last;
  logic [14:0] pend;
  logic [3:0]  pc;

  logic [4:0]  space;
  logic [4:0]  n;
  logic [16:0] rem_sh;
  logic [16:0] mask;
  logic [15:0] bits;
  logic [30:0] acc;
  logic [4:0]  newcnt;
  logic        full;
  logic [9:0]  r_after;
  logic        more;
  logic        out_free;
  logic        step_en;
  logic        chunk_end;
  logic        emit;

  assign busy     = (phase != P_IDLE);
  assign out_free = !out_valid || out_ready;
  assign step_en  = out_free && (phase == P_REM || phase == P_TAIL);

  // Load the output register with a full word or the flush word
  assign emit = (step_en && full) || ((phase == P_FLUSH) && out_free);

  // Take the next chunk that fits in the word being built
  always_comb begin
    space  = 5'd16 - {1'b0, pc};
    n      = space;
    bits   = 16'd0;
    rem_sh = rem_val >> (rem_left - n);
    mask   = (17'd1 << n) - 17'd1;
    r_after = tail_left;
    chunk_end = 1'b0;
    case (phase)
      P_REM: begin
        n       = (rem_left < space) ? rem_left : space;
        rem_sh  = rem_val >> (rem_left - n);
        mask    = (17'd1 << n) - 17'd1;
        bits    = 16'(rem_sh & mask);
        r_after = 10'(rem_left - n) + tail_left;
        chunk_end = (rem_left == n);
      end
      P_TAIL: begin
        n       = (tail_left < {5'd0, space}) ? tail_left[4:0] : space;
        bits    = ({5'd0, n} == tail_left) ? 16'd1 : 16'd0;
        r_after = tail_left - {5'd0, n};
        chunk_end = ({5'd0, n} == tail_left);
      end
      default: begin
        n = space;
      end
    endcase
    acc    = (31'(pend) << n) | 31'(bits);
    newcnt = 5'(pc) + n;
    full   = (newcnt == 5'd16);
    more   = (r_after >= 10'd16) || (is_last && (r_after != 10'd0));
  end

  // Sequence the code through the word buffer and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= P_IDLE;
      pend      <= '0;
      pc        <= '0;
      out_valid <= 1'b0;
      rem_val   <= '0;
      rem_left  <= '0;
      tail_left <= '0;
      is_last   <= 1'b0;
    end else begin
      if (out_valid && out_ready && !emit) begin
        out_valid <= 1'b0;
      end
      case (phase)
        P_IDLE: begin
          if (start) begin
            rem_val   <= 17'(cmd.m);
            rem_left  <= cmd.k;
            tail_left <= cmd.tail;
            is_last   <= cmd.last;
            phase     <= (cmd.k == 5'd0) ? P_TAIL : P_REM;
          end
        end
        P_REM, P_TAIL: begin
          if (step_en) begin
            if (full) begin
              out_valid  <= 1'b1;
              code_word  <= acc[15:0];
              byte_count <= BYTES_TWO;
              last_word  <= !more;
              pend       <= '0;
              pc         <= '0;
            end else begin
              pend <= acc[14:0];
              pc   <= newcnt[3:0];
            end
            if (phase == P_REM) begin
              rem_left <= rem_left - n;
              if (chunk_end) begin
                phase <= P_TAIL;
              end
            end else begin
              tail_left <= r_after;
              if (chunk_end) begin
                phase <= (is_last && !full && (newcnt != 5'd0)) ? P_FLUSH : P_IDLE;
              end
            end
          end
        end
        P_FLUSH: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            code_word  <= 16'(31'(pend) << (5'd16 - {1'b0, pc}));
            byte_count <= (pc <= 4'd8) ? BYTES_ONE : BYTES_TWO;
            last_word  <= 1'b1;
            pend       <= '0;
            pc         <= '0;
            phase      <= P_IDLE;
          end
        end
        default: begin
          phase <= P_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/context_golomb_image_coder_core.sv */
// From pixel accept the sequencer steps through S_READ, S_PRED, S_CTX, S_KMUL and
//   S_KSEL, where the code enters the packer, which sends it in chunks of up to 16
//   code bits while the output register is free; a chunk ends at a word boundary or
//   where the remainder bits end, and a last code may add a flush word. The next pixel
//   waits for the packer, so the context read-modify-write and the packer set the pace.
// Reset: synchronous; a sweep then loads every context, and the same
//   sweep follows each last pixel. No pixel is taken during a sweep.
`include "context_golomb_image_coder_core_defines.svh"

module context_golomb_image_coder_core
  import gcic_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // pixel channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  pixel,
  input  logic        last_pixel,
  // code channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] code_word,
  output logic [1:0]  byte_count,
  output logic        last_word,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_PRED, S_CTX, S_KMUL, S_KSEL, S_WAIT
  } state_t;

  state_t state;

  // Configuration registers
  logic [12:0] image_width;
  logic [7:0]  white_level;
  logic [8:0]  max_count;
  logic [11:0] init_sum;
  logic [8:0]  init_count;

  // Pixel position and neighbors
  logic [7:0]       left_pixel;
  logic [7:0]       upper_left_pixel;
  logic [COL_W-1:0] column_position;
  logic             in_first_row;

  // Per-pixel working registers
  logic [7:0]        x_reg;
  logic              last_reg;
  logic [7:0]        a_r, b_r, c_r;
  logic [10:0]       sum_r;
  logic [7:0]        p_r;
  logic [8:0]        m_r;
  logic [7:0]        abs_r;
  logic [CTX_AW-1:0] ctx_r;
  logic [SUM_W-1:0]  sa_r;
  logic [CNT_W-1:0]  sn_r;
  logic [35:0]       lhs_r;
  logic [17:0]       nn_r;

  // Clearing sweep
  logic [CTX_AW-1:0] clr_idx;
  logic [11:0]       clr_sum;
  logic [8:0]        clr_cnt;

  // Memories
  logic [7:0]        line_q;
  logic              line_we;
  logic [CTX_DW-1:0] ctx_q;
  logic [CTX_DW-1:0] ctx_wdata;
  logic [CTX_AW-1:0] ctx_addr;
  logic              ctx_we;

  // Packer
  logic      pk_start;
  logic      pk_busy;
  gcic_cmd_t pk_cmd;

  // Combinational helpers
  logic [7:0]         h;
  logic               col0;
  logic [7:0]         a_n, b_n, c_n;
  logic [12:0]        w_eff;
  logic [26:0]        prod;
  logic [7:0]         mn, mx, pred;
  logic signed [9:0]  e;
  logic signed [9:0]  ga, gb, gc;
  logic [CTX_AW-1:0]  ctx_n;
  logic [2*SUM_W-1:0] sa_sq;
  logic [53:0]        lhs_w;
  logic [4:0]         k;
  logic [CNT_W-1:0]   sn_h;
  logic [SUM_W-1:0]   sa_h;
  logic [SUM_W:0]     sa_sum;
  logic [SUM_W-1:0]   sa_new;

  assign pready   = 1'b1;
  assign in_ready = (state == S_IDLE);

  // Register read back
  always_comb begin
    case (paddr[4:2])
      REG_IMAGE_WIDTH: prdata = 32'(image_width);
      REG_WHITE_LEVEL: prdata = 32'(white_level);
      REG_MAX_COUNT:   prdata = 32'(max_count);
      REG_INIT_SUM:    prdata = 32'(init_sum);
      REG_INIT_COUNT:  prdata = 32'(init_count);
      default:         prdata = 32'd0;
    endcase
  end

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= RST_IMAGE_WIDTH;
      white_level <= RST_WHITE_LEVEL;
      max_count   <= RST_MAX_COUNT;
      init_sum    <= RST_INIT_SUM;
      init_count  <= RST_INIT_COUNT;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_IMAGE_WIDTH: image_width <= pwdata[12:0];
        REG_WHITE_LEVEL: white_level <= pwdata[7:0];
        REG_MAX_COUNT:   max_count   <= pwdata[8:0];
        REG_INIT_SUM:    init_sum    <= pwdata[11:0];
        REG_INIT_COUNT:  init_count  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // Neighbors, border value and row length
  always_comb begin
    h     = 8'((9'(white_level) + 9'd1) >> 1);
    col0  = (column_position == '0);
    a_n   = col0 ? h : left_pixel;
    b_n   = in_first_row ? h : line_q;
    c_n   = (col0 || in_first_row) ? h : upper_left_pixel;
    if (image_width == 13'd0) begin
      w_eff = 13'd1;
    end else if (image_width > 13'(MAX_WIDTH)) begin
      w_eff = 13'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
  end

  // Prediction and mapped error
  always_comb begin
    prod = 27'(sum_r) * 27'(RECIP6);
    mn   = (a_r < b_r) ? a_r : b_r;
    mx   = (a_r < b_r) ? b_r : a_r;
    if (c_r >= mx) begin
      pred = mn;
    end else if (c_r <= mn) begin
      pred = mx;
    end else begin
      pred = 8'(9'(a_r) + 9'(b_r) - 9'(c_r));
    end
    e = signed'({2'b00, x_reg}) - signed'({2'b00, pred});
  end

  // Context index from quantized gradients
  always_comb begin
    ga    = signed'({2'b00, a_r}) - signed'({2'b00, p_r});
    gb    = signed'({2'b00, b_r}) - signed'({2'b00, p_r});
    gc    = signed'({2'b00, c_r}) - signed'({2'b00, p_r});
    ctx_n = 9'(class9(ga)) * CTX_WA + 9'(class9(gb)) * CTX_WB + 9'(class5(gc));
  end

  // Full-width square of the error sum
  assign sa_sq = ctx_q[CTX_DW-1:CNT_W] * ctx_q[CTX_DW-1:CNT_W];

  // Rice parameter and context update
  always_comb begin
    lhs_w = 54'(lhs_r);
    k     = 5'd0;
    for (int j = 1; j <= 17; j++) begin
      if (lhs_w >= (54'(nn_r) << (2 * j))) begin
        k = k + 5'd1;
      end
    end
    if (sn_r == '0 || sa_r == '0) begin
      k = 5'd0;
    end
    sn_h   = (sn_r == max_count) ? (sn_r >> 1) : sn_r;
    sa_h   = (sn_r == max_count) ? (sa_r >> 1) : sa_r;
    sa_sum = 18'(sa_h) + 18'(abs_r);
    sa_new = (sa_sum > SUM_MAX) ? SUM_MAX[SUM_W-1:0] : sa_sum[SUM_W-1:0];
  end

  // Memory ports and packer command
  always_comb begin
    line_we   = (state == S_READ);
    ctx_we    = (state == S_CLEAR) || (state == S_KSEL);
    ctx_addr  = ctx_n;
    ctx_wdata = {sa_new, sn_h + 9'd1};
    if (state == S_CLEAR) begin
      ctx_addr  = clr_idx;
      ctx_wdata = {17'(clr_sum), clr_cnt};
    end else if (state == S_KSEL) begin
      ctx_addr = ctx_r;
    end
    pk_start    = (state == S_KSEL);
    pk_cmd.k    = k;
    pk_cmd.m    = m_r;
    pk_cmd.tail = 10'(m_r >> k) + 10'd1;
    pk_cmd.last = last_reg;
  end

  gcic_ram #(.DEPTH(MAX_WIDTH), .WIDTH(PIXEL_BITS)) u_line (
    .clk   (clk),
    .we    (line_we),
    .addr  (column_position),
    .wdata (x_reg),
    .rdata (line_q)
  );

  gcic_ram #(.DEPTH(CONTEXT_COUNT), .WIDTH(CTX_DW)) u_ctx (
    .clk   (clk),
    .we    (ctx_we),
    .addr  (ctx_addr),
    .wdata (ctx_wdata),
    .rdata (ctx_q)
  );

  gcic_packer u_packer (
    .clk        (clk),
    .rst        (rst),
    .start      (pk_start),
    .cmd        (pk_cmd),
    .busy       (pk_busy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_word  (code_word),
    .byte_count (byte_count),
    .last_word  (last_word)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLEAR;
      clr_idx          <= '0;
      clr_sum          <= RST_INIT_SUM;
      clr_cnt          <= RST_INIT_COUNT;
      left_pixel       <= '0;
      upper_left_pixel <= '0;
      column_position  <= '0;
      in_first_row     <= 1'b1;
      last_reg         <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (clr_idx == CTX_LAST) begin
            state <= S_IDLE;
          end else begin
            clr_idx <= clr_idx + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            x_reg    <= pixel;
            last_reg <= last_pixel;
            state    <= S_READ;
          end
        end
        S_READ: begin
          a_r   <= a_n;
          b_r   <= b_n;
          c_r   <= c_n;
          sum_r <= 11'({a_n, 1'b0}) + 11'({b_n, 1'b0}) + 11'({c_n, 1'b0}) + 11'd3;
          upper_left_pixel <= in_first_row ? 8'd0 : line_q;
          left_pixel       <= x_reg;
          if ((13'(column_position) + 13'd1) >= w_eff) begin
            column_position <= '0;
            in_first_row    <= 1'b0;
          end else begin
            column_position <= column_position + 1'b1;
          end
          state <= S_PRED;
        end
        S_PRED: begin
          p_r   <= prod[RECIP6_SHIFT +: 8];
          m_r   <= e[9] ? 9'(10'(-e) * 10'd2 - 10'd1) : 9'(10'(e) * 10'd2);
          abs_r <= e[9] ? 8'(-e) : 8'(e);
          state <= S_CTX;
        end
        S_CTX: begin
          ctx_r <= ctx_n;
          state <= S_KMUL;
        end
        S_KMUL: begin
          sa_r  <= ctx_q[CTX_DW-1:CNT_W];
          sn_r  <= ctx_q[CNT_W-1:0];
          lhs_r <= {1'b0, sa_sq, 1'b0};
          nn_r  <= ctx_q[CNT_W-1:0] * ctx_q[CNT_W-1:0];
          state <= S_KSEL;
        end
        S_KSEL: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (!pk_busy) begin
            if (last_reg) begin
              left_pixel       <= '0;
              upper_left_pixel <= '0;
              column_position  <= '0;
              in_first_row     <= 1'b1;
              clr_idx          <= '0;
              clr_sum          <= init_sum;
              clr_cnt          <= init_count;
              state            <= S_CLEAR;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  `GCIC_ASSERT_NOW(a_idle_packer, in_ready, !pk_busy, "pixel taken while packer busy")
  `GCIC_ASSERT_NOW(a_bytes, out_valid, (byte_count == BYTES_ONE) || (byte_count == BYTES_TWO), "bad byte count")
  `GCIC_ASSERT_NOW(a_short_last, out_valid && (byte_count == BYTES_ONE), last_word, "short word not last")
  `GCIC_ASSERT_NOW(a_ctx_range, ctx_we, ctx_addr <= CTX_LAST, "context index out of range")
  `GCIC_ASSERT_NEXT(a_start_busy, pk_start, pk_busy, "packer did not start")

endmodule
